### rtl/rpcv_pkg.sv
`default_nettype none

package rpcv_pkg;

    localparam int unsigned HEADER_BYTES = 26;
    localparam int unsigned POS_W = 5;

    localparam logic [POS_W-1:0] POS_FLAGS     = POS_W'(1);
    localparam logic [POS_W-1:0] POS_PROC_END  = POS_W'(10);
    localparam logic [POS_W-1:0] POS_SIZE_END  = POS_W'(14);
    localparam logic [POS_W-1:0] POS_CALL_END  = POS_W'(22);
    localparam logic [POS_W-1:0] POS_HDR_DONE  = POS_W'(HEADER_BYTES);

    localparam logic [31:0] CRC_INIT  = 32'hffff_ffff;
    localparam logic [31:0] COUNT_MAX = 32'hffff_ffff;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_BAD_OP    = 3'd1,
        STATUS_OVER_MAX  = 3'd2,
        STATUS_LEN_DIFF  = 3'd3,
        STATUS_CRC_BAD   = 3'd4,
        STATUS_SHORT_HDR = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        REG_OP_CALL       = 3'd0,
        REG_OP_PING       = 3'd1,
        REG_OP_DISCONNECT = 3'd2,
        REG_OP_RESPONSE   = 3'd3,
        REG_OP_ERROR      = 3'd4,
        REG_MAX_PAYLOAD   = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] computed_checksum;
        logic [31:0] stored_checksum;
        logic [7:0]  op_code;
        logic [7:0]  flag_bits;
        logic [63:0] procedure_id;
        logic [31:0] declared_size;
        logic [63:0] call_identifier;
    } result_item_t;

    typedef struct packed {
        logic [7:0]  op_call;
        logic [7:0]  op_ping;
        logic [7:0]  op_disconnect;
        logic [7:0]  op_response;
        logic [7:0]  op_error;
        logic [31:0] max_payload;
    } cfg_t;

    function automatic logic [31:0] crc_nibble(input logic [3:0] n);
        logic [31:0] r;
        case (n)
            4'h0: r = 32'h0000_0000;
            4'h1: r = 32'h105e_c76f;
            4'h2: r = 32'h20bd_8ede;
            4'h3: r = 32'h30e3_49b1;
            4'h4: r = 32'h417b_1dbc;
            4'h5: r = 32'h5125_dad3;
            4'h6: r = 32'h61c6_9362;
            4'h7: r = 32'h7198_540d;
            4'h8: r = 32'h82f6_3b78;
            4'h9: r = 32'h92a8_fc17;
            4'ha: r = 32'ha24b_b5a6;
            4'hb: r = 32'hb215_72c9;
            4'hc: r = 32'hc38d_26c4;
            4'hd: r = 32'hd3d3_e1ab;
            4'he: r = 32'he330_a81a;
            default: r = 32'hf36e_6f75;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] crc32c_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] t;
        t = c ^ {24'd0, b};
        t = (t >> 4) ^ crc_nibble(t[3:0]);
        t = (t >> 4) ^ crc_nibble(t[3:0]);
        return t;
    endfunction

endpackage

`default_nettype wire

### rtl/rpcv_cfg_regs.sv
`default_nettype none

module rpcv_cfg_regs
    import rpcv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (reg_index_t'(cfg_index))
                REG_OP_CALL:       cfg_next.op_call       = cfg_data[7:0];
                REG_OP_PING:       cfg_next.op_ping       = cfg_data[7:0];
                REG_OP_DISCONNECT: cfg_next.op_disconnect = cfg_data[7:0];
                REG_OP_RESPONSE:   cfg_next.op_response   = cfg_data[7:0];
                REG_OP_ERROR:      cfg_next.op_error      = cfg_data[7:0];
                REG_MAX_PAYLOAD:   cfg_next.max_payload   = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.op_call       <= 8'd0;
            cfg_reg.op_ping       <= 8'd1;
            cfg_reg.op_disconnect <= 8'd2;
            cfg_reg.op_response   <= 8'd3;
            cfg_reg.op_error      <= 8'd4;
            cfg_reg.max_payload   <= 32'd1048576;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/rpcv_packet_state.sv
`default_nettype none

module rpcv_packet_state
    import rpcv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire byte_item_t  item,
    input  wire cfg_t        cfg,
    output result_item_t     result
);

    logic [POS_W-1:0] pos_reg,      pos_next;
    logic [31:0]      crc_reg,      crc_next;
    logic [7:0]       op_reg,       op_next;
    logic [7:0]       flags_reg,    flags_next;
    logic [63:0]      proc_reg,     proc_next;
    logic [31:0]      size_reg,     size_next;
    logic [63:0]      call_reg,     call_next;
    logic [31:0]      csum_reg,     csum_next;
    logic [31:0]      count_reg,    count_next;
    logic [7:0]       fed;
    logic [31:0]      crc_out;
    logic             op_known;
    status_t          st;

    always_comb
    begin
        pos_next   = pos_reg;
        op_next    = op_reg;
        flags_next = flags_reg;
        proc_next  = proc_reg;
        size_next  = size_reg;
        call_next  = call_reg;
        csum_next  = csum_reg;
        count_next = count_reg;
        fed        = item.data_byte;
        if (pos_reg < POS_HDR_DONE)
        begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg == '0)
                op_next = item.data_byte;
            else if (pos_reg == POS_FLAGS)
                flags_next = item.data_byte;
            else if (pos_reg < POS_PROC_END)
                proc_next = {proc_reg[55:0], item.data_byte};
            else if (pos_reg < POS_SIZE_END)
                size_next = {size_reg[23:0], item.data_byte};
            else if (pos_reg < POS_CALL_END)
                call_next = {call_reg[55:0], item.data_byte};
            else
            begin
                csum_next = {csum_reg[23:0], item.data_byte};
                fed = 8'd0;
            end
        end
        else if (count_reg != COUNT_MAX)
        begin
            count_next = count_reg + 32'd1;
        end
        crc_next = crc32c_byte(crc_reg, fed);
        crc_out  = ~crc_next;

        op_known = (op_next == cfg.op_call) || (op_next == cfg.op_ping)
                || (op_next == cfg.op_disconnect) || (op_next == cfg.op_response)
                || (op_next == cfg.op_error);

        if (!op_known)
            st = STATUS_BAD_OP;
        else if (size_next > cfg.max_payload)
            st = STATUS_OVER_MAX;
        else if (count_next != size_next)
            st = STATUS_LEN_DIFF;
        else if (crc_out != csum_next)
            st = STATUS_CRC_BAD;
        else
            st = STATUS_OK;

        if (pos_next < POS_HDR_DONE)
        begin
            result        = '0;
            result.status = STATUS_SHORT_HDR;
        end
        else
        begin
            result.status            = st;
            result.computed_checksum = crc_out;
            result.stored_checksum   = csum_next;
            result.op_code           = op_next;
            result.flag_bits         = flags_next;
            result.procedure_id      = proc_next;
            result.declared_size     = size_next;
            result.call_identifier   = call_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            crc_reg   <= CRC_INIT;
            op_reg    <= '0;
            flags_reg <= '0;
            proc_reg  <= '0;
            size_reg  <= '0;
            call_reg  <= '0;
            csum_reg  <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            if (item.last_byte)
            begin
                pos_reg   <= '0;
                crc_reg   <= CRC_INIT;
                op_reg    <= '0;
                flags_reg <= '0;
                proc_reg  <= '0;
                size_reg  <= '0;
                call_reg  <= '0;
                csum_reg  <= '0;
                count_reg <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                crc_reg   <= crc_next;
                op_reg    <= op_next;
                flags_reg <= flags_next;
                proc_reg  <= proc_next;
                size_reg  <= size_next;
                call_reg  <= call_next;
                csum_reg  <= csum_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/rpc_packet_crc32c_verifier_core.sv
`default_nettype none

// Checks a packet that arrives one byte per item on the byte channel. The first
// 26 bytes are the big-endian header; the rest is payload. A CRC-32C runs over
// the header, with its checksum bytes taken as zero, and over the payload.
// On the item that carries last_byte, one result item leaves on the result
// channel with the decoded header, the computed checksum and a status.
// The configuration port sets the five known op codes and the largest allowed
// payload size; the user must write it only while no packet is in flight, as the block itself does not enforce this.
// A byte is registered in in_item_reg at acceptance and processed from there;
// the result of the last byte is registered in res_item_reg, with result_valid
// raised from res_valid_reg.
// One byte is taken in every cycle unless byte_stall holds the channel; the
// byte-wide CRC update and header capture are combinational.
// When the receiver stalls, the result is held in the output register and the
// byte channel keeps flowing until a second last byte would need that register.
// Reset clears the packet state and restores the register defaults.
module rpc_packet_crc32c_verifier_core
    import rpcv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire byte_item_t  byte_item,
    output logic             result_valid,
    input  wire logic        result_stall,
    output result_item_t     result_item,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cfg_t         cfg;
    logic         in_valid_reg;
    byte_item_t   in_item_reg;
    logic         advance;
    logic         res_valid_reg;
    result_item_t res_item_reg;
    result_item_t res_comb;

    rpcv_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance = in_valid_reg
                  && (!in_item_reg.last_byte || !res_valid_reg || !result_stall);
    assign byte_stall = in_valid_reg && !advance;

    rpcv_packet_state u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            in_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            in_item_reg <= byte_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance && in_item_reg.last_byte)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_item_reg.last_byte)
        begin
            res_item_reg <= res_comb;
        end
    end

    assign result_valid = res_valid_reg;
    assign result_item  = res_item_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && in_item_reg.last_byte && res_valid_reg && result_stall
        |-> byte_stall)
        else $error("Held result would be overwritten by a new packet end.");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_item_reg.status == STATUS_SHORT_HDR)
        |-> (res_item_reg.computed_checksum == '0) && (res_item_reg.op_code == '0))
        else $error("Short header result carries nonzero fields.");

    a_ok_match: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_item_reg.status == STATUS_OK)
        |-> (res_item_reg.computed_checksum == res_item_reg.stored_checksum))
        else $error("Result reported ok with mismatched checksums.");

endmodule

`default_nettype wire
